// ===== design/gge_pkg.sv =====
package gge_pkg;

  localparam int TimeFrac = 16;
  localparam int CfgIdxW  = 3;

  localparam logic [CfgIdxW-1:0] CfgRateMrnaMake    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgRateProteinMake = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgRateMrnaDecay   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgRateProtDecay   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgGeneCopies      = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgDivisionTime    = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgInitialVolume   = 3'd6;

  localparam logic [2:0] RxnMrnaMake  = 3'd0;
  localparam logic [2:0] RxnProtMake  = 3'd1;
  localparam logic [2:0] RxnMrnaDecay = 3'd2;
  localparam logic [2:0] RxnProtDecay = 3'd3;
  localparam logic [2:0] RxnNone      = 3'd4;

  // ln(2) in Q0.32
  localparam logic [31:0] Ln2Q32 = 32'd2977044472;

  typedef logic [31:0][31:0] ctab_t;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [47:0] den;
  } div_req_t;

  // square-root chain of two: entry k is 2^(2^-(k+1)) in Q1.31, truncated at each step
  function automatic ctab_t exp_ctab();
    ctab_t       t;
    logic [63:0] c;
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] b;
    c = 64'h1_0000_0000;
    for (int k = 0; k < 32; k++) begin
      v   = c << 31;
      res = '0;
      for (int j = 0; j < 32; j++) begin
        b = 64'd1 << (62 - 2 * j);
        if (v >= res + b) begin
          v   = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
      end
      c    = res;
      t[k] = c[31:0];
    end
    return t;
  endfunction

endpackage

// ===== design/gge_mul.sv =====
module gge_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= 64'(a_i) * 64'(b_i);
  end

  assign p_o = p_q;

endmodule

// ===== design/gge_div.sv =====
module gge_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gge_pkg::div_req_t req_i,
  output logic              done_o,
  output logic [63:0]       quo_o
);

  logic [63:0] nq_q;
  logic [47:0] rem_q;
  logic [6:0]  cnt_q;
  logic        busy_q;
  logic        done_q;
  logic [48:0] rem_sh;
  logic        ge;

  assign rem_sh = {rem_q, nq_q[63]};
  assign ge     = rem_sh >= {1'b0, req_i.den};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      nq_q   <= '0;
      rem_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        nq_q   <= req_i.num;
        rem_q  <= '0;
        cnt_q  <= 7'd64;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= ge ? 48'(rem_sh - {1'b0, req_i.den}) : rem_sh[47:0];
        nq_q  <= {nq_q[62:0], ge};
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = nq_q;

endmodule

// ===== design/gillespie_gene_expression_step_unit.sv =====
// One word in, one word out. The longest path, for a step word, runs through four propensity
// products, 24 log squarings, a 64-step division for tau, the pick, a 64-step division for
// the volume exponent and up to 32 root-factor products; a load already past the division
// time goes to the output without a division. Everything goes through one registered 32x32
// multiplier and a one-bit-per-cycle divider. A new word is taken only in idle; the last
// result may still wait in the output register. Reset sets the config registers to their
// defaults and clears counts, times and divisions.
module gillespie_gene_expression_step_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // uniform_wait, uniform_pick, load_mrna, load_protein, load_since_division, load_elapsed
  input  logic [175:0] s_axis_tdata,
  // action
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // reaction, wait_time, elapsed_time, mrna_count, protein_count, volume, divided,
  // division_count, zero pad
  output logic [167:0] m_axis_tdata
);

  localparam gge_pkg::ctab_t CTab = gge_pkg::exp_ctab();

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StHProp = 4'd1;
  localparam logic [3:0] StHDone = 4'd2;
  localparam logic [3:0] StLog   = 4'd3;
  localparam logic [3:0] StLn    = 4'd4;
  localparam logic [3:0] StDivT  = 4'd5;
  localparam logic [3:0] StTgt   = 4'd6;
  localparam logic [3:0] StPick  = 4'd7;
  localparam logic [3:0] StUpd   = 4'd8;
  localparam logic [3:0] StVChk  = 4'd9;
  localparam logic [3:0] StDivV  = 4'd10;
  localparam logic [3:0] StExp   = 4'd11;
  localparam logic [3:0] StVMul  = 4'd12;
  localparam logic [3:0] StOut   = 4'd13;

  // config
  logic [31:0] rmm_q, rpm_q, rmd_q, rpd_q, td_q, iv_q;
  logic [7:0]  gc_q;
  // cell state
  logic [15:0] mrna_q, prot_q, divcnt_q;
  logic [47:0] elap_q;
  logic [31:0] since_q;
  // sequencer and work registers
  logic [3:0]  st_q;
  logic        ph_q;
  logic [4:0]  k_q;
  logic [31:0] u1_q, u2_q;
  logic [47:0] h_q [4];
  logic [47:0] total_q, tgt_q, cum_q;
  logic [31:0] m_q, tau_q, x_q, r_q, vol_q;
  logic [4:0]  e_q;
  logic [23:0] f_q;
  logic [2:0]  rxn_q;
  logic        divd_q;
  logic        div_go_q;
  logic [63:0] div_num_q;
  logic [47:0] div_den_q;
  logic        m_valid_q;
  logic [163:0] m_data_q;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic        div_done;
  logic [63:0] quo;
  gge_pkg::div_req_t div_req;

  logic [4:0]  e_c;
  logic [31:0] m_norm;
  logic [29:0] neg_c;
  logic [32:0] sq;
  logic [47:0] cum_d;
  logic [48:0] el_sum;
  logic [47:0] el_new;
  logic [32:0] si_sum;
  logic [31:0] si_new;
  logic [32:0] iv2;
  logic [15:0] mrna_d, prot_d;

  gge_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign div_req = '{start: div_go_q, num: div_num_q, den: div_den_q};

  gge_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (quo)
  );

  always_comb begin
    e_c = '0;
    for (int i = 0; i < 32; i++) begin
      if (u1_q[i]) e_c = 5'(i);
    end
  end

  assign m_norm = u1_q << (5'd31 - e_c);
  assign neg_c  = 30'h2000_0000 - {1'b0, e_q, f_q};
  assign sq     = prod[63:31];
  assign cum_d  = cum_q + h_q[k_q[1:0]];
  assign el_sum = {1'b0, elap_q} + 49'(tau_q);
  assign el_new = el_sum[48] ? '1 : el_sum[47:0];
  assign si_sum = {1'b0, since_q} + {1'b0, tau_q};
  assign si_new = si_sum[32] ? '1 : si_sum[31:0];
  assign iv2    = {iv_q, 1'b0};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (st_q)
      StHProp: begin
        case (k_q[1:0])
          2'd0:    begin mul_a = rmm_q; mul_b = 32'(gc_q);   end
          2'd1:    begin mul_a = rpm_q; mul_b = 32'(mrna_q); end
          2'd2:    begin mul_a = rmd_q; mul_b = 32'(mrna_q); end
          default: begin mul_a = rpd_q; mul_b = 32'(prot_q); end
        endcase
      end
      StLog: begin
        mul_a = m_q;
        mul_b = m_q;
      end
      StLn: begin
        mul_a = 32'(neg_c);
        mul_b = gge_pkg::Ln2Q32;
      end
      StTgt: begin
        mul_a = u2_q;
        mul_b = (k_q == 5'd0) ? 32'(total_q[47:32]) : total_q[31:0];
      end
      StExp: begin
        mul_a = r_q;
        mul_b = CTab[k_q];
      end
      StVMul: begin
        mul_a = iv_q;
        mul_b = r_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    mrna_d = mrna_q;
    prot_d = prot_q;
    case (rxn_q)
      gge_pkg::RxnMrnaMake:  if (mrna_q != '1) mrna_d = mrna_q + 16'd1;
      gge_pkg::RxnProtMake:  if (prot_q != '1) prot_d = prot_q + 16'd1;
      gge_pkg::RxnMrnaDecay: if (mrna_q != '0) mrna_d = mrna_q - 16'd1;
      gge_pkg::RxnProtDecay: if (prot_q != '0) prot_d = prot_q - 16'd1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rmm_q     <= 32'd1288490189;
      rpm_q     <= 32'd214748365;
      rmd_q     <= 32'd214748365;
      rpd_q     <= 32'd214748;
      gc_q      <= 8'd1;
      td_q      <= 32'd235929600;
      iv_q      <= 32'd16777216;
      mrna_q    <= '0;
      prot_q    <= '0;
      elap_q    <= '0;
      since_q   <= '0;
      divcnt_q  <= '0;
      st_q      <= StIdle;
      ph_q      <= 1'b0;
      k_q       <= '0;
      div_go_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      div_go_q <= 1'b0;
      if (m_valid_q && m_axis_tready) m_valid_q <= 1'b0;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          gge_pkg::CfgRateMrnaMake:    rmm_q <= cfg_wdata_i;
          gge_pkg::CfgRateProteinMake: rpm_q <= cfg_wdata_i;
          gge_pkg::CfgRateMrnaDecay:   rmd_q <= cfg_wdata_i;
          gge_pkg::CfgRateProtDecay:   rpd_q <= cfg_wdata_i;
          gge_pkg::CfgGeneCopies:      gc_q  <= cfg_wdata_i[7:0];
          gge_pkg::CfgDivisionTime:    td_q  <= cfg_wdata_i;
          gge_pkg::CfgInitialVolume:   iv_q  <= cfg_wdata_i;
          default: ;
        endcase
      end

      case (st_q)
        StIdle: begin
          if (s_axis_tvalid) begin
            u1_q    <= s_axis_tdata[31:0];
            u2_q    <= s_axis_tdata[63:32];
            k_q     <= '0;
            ph_q    <= 1'b0;
            total_q <= '0;
            rxn_q   <= gge_pkg::RxnNone;
            divd_q  <= 1'b0;
            if (s_axis_tuser) begin
              mrna_q   <= s_axis_tdata[79:64];
              prot_q   <= s_axis_tdata[95:80];
              since_q  <= s_axis_tdata[127:96];
              elap_q   <= s_axis_tdata[175:128];
              divcnt_q <= '0;
              tau_q    <= '0;
              st_q     <= StVChk;
            end else begin
              st_q <= StHProp;
            end
          end
        end
        StHProp: begin
          ph_q <= ~ph_q;
          if (ph_q) begin
            h_q[k_q[1:0]] <= prod[49:2];
            total_q       <= total_q + prod[49:2];
            if (k_q == 5'd3) st_q <= StHDone;
            else k_q <= k_q + 5'd1;
          end
        end
        StHDone: begin
          k_q  <= '0;
          ph_q <= 1'b0;
          if (total_q == '0) begin
            tau_q <= '1;
            st_q  <= StUpd;
          end else if (u1_q == '0) begin
            tau_q <= '1;
            st_q  <= StTgt;
          end else begin
            m_q  <= m_norm;
            e_q  <= e_c;
            f_q  <= '0;
            st_q <= StLog;
          end
        end
        StLog: begin
          ph_q <= ~ph_q;
          if (ph_q) begin
            f_q <= {f_q[22:0], sq[32]};
            m_q <= sq[32] ? sq[32:1] : sq[31:0];
            if (k_q == 5'd23) begin
              k_q  <= '0;
              st_q <= StLn;
            end else begin
              k_q <= k_q + 5'd1;
            end
          end
        end
        StLn: begin
          ph_q <= ~ph_q;
          if (ph_q) begin
            div_num_q <= 64'(prod[63:32]) << (gge_pkg::TimeFrac + 6);
            div_den_q <= total_q;
            div_go_q  <= 1'b1;
            st_q      <= StDivT;
          end
        end
        StDivT: begin
          if (div_done) begin
            tau_q <= (quo[63:32] != '0) ? '1 : quo[31:0];
            k_q   <= '0;
            ph_q  <= 1'b0;
            st_q  <= StTgt;
          end
        end
        StTgt: begin
          ph_q <= ~ph_q;
          if (ph_q) begin
            if (k_q == 5'd0) begin
              tgt_q <= prod[47:0];
              k_q   <= 5'd1;
            end else begin
              tgt_q <= tgt_q + 48'(prod[63:32]);
              k_q   <= '0;
              cum_q <= '0;
              st_q  <= StPick;
            end
          end
        end
        StPick: begin
          cum_q <= cum_d;
          if (cum_d > tgt_q) begin
            rxn_q <= 3'(k_q[1:0]);
            st_q  <= StUpd;
          end else if (k_q == 5'd3) begin
            st_q <= StUpd;
          end else begin
            k_q <= k_q + 5'd1;
          end
        end
        StUpd: begin
          mrna_q <= mrna_d;
          prot_q <= prot_d;
          elap_q <= el_new;
          if (si_new >= td_q) begin
            since_q <= '0;
            if (divcnt_q != '1) divcnt_q <= divcnt_q + 16'd1;
            divd_q  <= 1'b1;
            vol_q   <= iv_q;
            st_q    <= StOut;
          end else begin
            since_q   <= si_new;
            div_num_q <= {si_new, 32'd0};
            div_den_q <= 48'(td_q);
            div_go_q  <= 1'b1;
            st_q      <= StDivV;
          end
        end
        StVChk: begin
          if (since_q >= td_q) begin
            vol_q <= iv2[32] ? '1 : iv2[31:0];
            st_q  <= StOut;
          end else begin
            div_num_q <= {since_q, 32'd0};
            div_den_q <= 48'(td_q);
            div_go_q  <= 1'b1;
            st_q      <= StDivV;
          end
        end
        StDivV: begin
          if (div_done) begin
            x_q  <= quo[31:0];
            r_q  <= 32'h8000_0000;
            k_q  <= '0;
            ph_q <= 1'b0;
            st_q <= StExp;
          end
        end
        StExp: begin
          // bits of the exponent from the top; a set bit multiplies in its root factor
          if (!ph_q && x_q[~k_q]) begin
            ph_q <= 1'b1;
          end else begin
            if (ph_q) r_q <= prod[62:31];
            ph_q <= 1'b0;
            if (k_q == 5'd31) st_q <= StVMul;
            else k_q <= k_q + 5'd1;
          end
        end
        StVMul: begin
          ph_q <= ~ph_q;
          if (ph_q) begin
            vol_q <= sq[32] ? '1 : sq[31:0];
            st_q  <= StOut;
          end
        end
        StOut: begin
          if (!m_valid_q || m_axis_tready) begin
            m_data_q  <= {divcnt_q, divd_q, vol_q, prot_q, mrna_q, elap_q, tau_q, rxn_q};
            m_valid_q <= 1'b1;
            st_q      <= StIdle;
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  assign s_axis_tready = (st_q == StIdle);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'd0, m_data_q};

endmodule
